[hdl/pqrle_pkg.sv]
// shared constants, types and helpers for the palette quantiser and run-length encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pqrle_pkg;

  localparam int LineWidth   = 320;
  localparam int MaxRun      = 255;
  localparam int PaletteSize = 16;

  localparam int NumPairs   = 8;
  localparam int NumEntries = 16;
  localparam int EntryW     = 24;
  localparam int CompW      = 8;
  localparam int CfgDataW   = 2 * EntryW;
  localparam int CfgIdxW    = 4;
  localparam int PairIdxW   = $clog2(NumPairs);
  localparam int IdxW       = $clog2(NumEntries);
  localparam int RunW       = 8;
  localparam int SqW        = 2 * CompW;
  localparam int DistW      = SqW + 2;
  localparam int ColW       = (LineWidth > 1) ? $clog2(LineWidth) : 1;
  localparam int FifoDepth  = 4;
  localparam int FifoPtrW   = $clog2(FifoDepth);
  localparam int FifoCntW   = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [DistW-1:0] sq_sum;
    logic [IdxW-1:0]  idx;
  } cand_t;

  typedef struct packed {
    logic [RunW-1:0] run_len;
    logic [IdxW-1:0] colour_idx;
    logic            end_of_line;
    logic            last_of_item;
  } result_t;

  // fifo handshake between classifier and encoder
  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] idx;
  } qpush_t;

  typedef struct packed {
    logic            valid;
    logic [IdxW-1:0] idx;
  } qhead_t;

  // lower index wins a tie
  function automatic cand_t pick_min(input cand_t lo, input cand_t hi);
    pick_min = (hi.sq_sum < lo.sq_sum) ? hi : lo;
  endfunction

  function automatic logic [SqW-1:0] sq_diff(input logic [CompW-1:0] a,
                                            input logic [CompW-1:0] b);
    logic [CompW-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    sq_diff = SqW'(d) * SqW'(d);
  endfunction

endpackage

`default_nettype wire

[hdl/pqrle_if.sv]
// channel interfaces: pixel input, run output, palette configuration
// depends on pqrle_pkg
`timescale 1ns / 1ps
`default_nettype none

interface pqrle_pix_if import pqrle_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CompW-1:0] red;
  logic [CompW-1:0] green;
  logic [CompW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface pqrle_res_if import pqrle_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RunW-1:0] run_len;
  logic [IdxW-1:0] colour_idx;
  logic            end_of_line;
  logic            last_of_item;

  modport source (output valid, output run_len, output colour_idx, output end_of_line,
                  output last_of_item, input ready);
  modport sink   (input valid, input run_len, input colour_idx, input end_of_line,
                  input last_of_item, output ready);
endinterface

interface pqrle_cfg_if import pqrle_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/pqrle_classify.sv]
// front end: palette registers and three-stage nearest-colour search
// depends on pqrle_pkg and pqrle_if
`timescale 1ns / 1ps
`default_nettype none

module pqrle_classify import pqrle_pkg::*; (
  input  wire             clk_i,
  input  wire             rst_ni,
  pqrle_pix_if.sink       pix_i,
  pqrle_cfg_if.sink       cfg_i,
  input  wire             q_full_i,
  output qpush_t          push_o
);

  logic [NumPairs-1:0][CfgDataW-1:0]  pal_q;
  logic [NumEntries-1:0][EntryW-1:0]  entries;
  logic [NumEntries-1:0][DistW-1:0]   dist_d, dist_q;
  cand_t [3:0]                        grp_d, grp_q;
  cand_t                              best_d;
  logic [IdxW-1:0]                    best_q;
  logic                               v1_q, v2_q, v3_q;
  logic                               adv;

  assign cfg_i.ready = 1'b1;
  assign entries     = pal_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_q <= '0;
    end else if (cfg_i.valid && (cfg_i.index < CfgIdxW'(NumPairs))) begin
      pal_q[cfg_i.index[PairIdxW-1:0]] <= cfg_i.data;
    end
  end

  assign adv         = !v3_q || !q_full_i;
  assign pix_i.ready = adv;

  always_comb begin
    for (int i = 0; i < NumEntries; i++) begin
      if (i < PaletteSize) begin
        dist_d[i] = DistW'(sq_diff(pix_i.red,   entries[i][23:16]))
                  + DistW'(sq_diff(pix_i.green, entries[i][15:8]))
                  + DistW'(sq_diff(pix_i.blue,  entries[i][7:0]));
      end else begin
        dist_d[i] = '1;
      end
    end
  end

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      grp_d[g] = pick_min(
        pick_min(cand_t'{dist_q[4*g],   IdxW'(4*g)},   cand_t'{dist_q[4*g+1], IdxW'(4*g+1)}),
        pick_min(cand_t'{dist_q[4*g+2], IdxW'(4*g+2)}, cand_t'{dist_q[4*g+3], IdxW'(4*g+3)}));
    end
    best_d = pick_min(pick_min(grp_q[0], grp_q[1]), pick_min(grp_q[2], grp_q[3]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= pix_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q <= dist_d;
      grp_q  <= grp_d;
      best_q <= best_d.idx;
    end
  end

  assign push_o.valid = v3_q && !q_full_i;
  assign push_o.idx   = best_q;

endmodule

`default_nettype wire

[hdl/pqrle_fifo.sv]
// short queue of colour indices between classifier and encoder
// depends on pqrle_pkg
`timescale 1ns / 1ps
`default_nettype none

module pqrle_fifo import pqrle_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire qpush_t  push_i,
  input  wire          pop_i,
  output logic         full_o,
  output qhead_t       head_o
);

  logic [FifoDepth-1:0][IdxW-1:0] mem_q;
  logic [FifoPtrW-1:0]            wr_q, rd_q;
  logic [FifoCntW-1:0]            cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o       = (cnt_q == FifoCntW'(FifoDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.idx   = mem_q[rd_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.idx;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FifoCntW'(FifoDepth))
    else $error("queue count beyond depth");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) || (cnt_q == FifoCntW'(FifoDepth)) || (wr_q != rd_q))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

[hdl/pqrle_rle.sv]
// back end: run tracking per scanline and registered run output
// depends on pqrle_pkg and pqrle_if
`timescale 1ns / 1ps
`default_nettype none

module pqrle_rle import pqrle_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire qhead_t  head_i,
  output logic         pop_o,
  pqrle_res_if.source  res_o
);

  logic [IdxW-1:0] run_color_q, run_color_d;
  logic [RunW-1:0] run_count_q, run_count_d;
  logic [ColW-1:0] column_q, column_d;
  logic            out_valid_q, out_valid_d;
  result_t         out_q, out_d;
  logic            pend_q, pend_d;
  result_t         pend_res_q, pend_res_d;

  logic            has_item, line_end, close_old, close_new, emits, load_ok;
  logic [RunW-1:0] new_cnt;
  result_t         old_res, new_res;

  always_comb begin
    has_item  = head_i.valid && !pend_q;
    line_end  = (column_q == ColW'(LineWidth - 1));
    close_old = (run_count_q != '0) && (head_i.idx != run_color_q);
    new_cnt   = (close_old || run_count_q == '0) ? RunW'(1) : run_count_q + 1'b1;
    close_new = (new_cnt >= RunW'(MaxRun)) || line_end;
    emits     = close_old || close_new;
    load_ok   = !out_valid_q || res_o.ready;
    pop_o     = has_item && (!emits || load_ok);

    old_res = '{run_len: run_count_q, colour_idx: run_color_q,
                end_of_line: 1'b0, last_of_item: !close_new};
    new_res = '{run_len: new_cnt, colour_idx: head_i.idx,
                end_of_line: line_end, last_of_item: 1'b1};

    run_color_d = run_color_q;
    run_count_d = run_count_q;
    column_d    = column_q;
    if (pop_o) begin
      if (close_old || run_count_q == '0) begin
        run_color_d = head_i.idx;
      end
      run_count_d = close_new ? '0 : new_cnt;
      column_d    = line_end ? '0 : column_q + 1'b1;
    end

    out_valid_d = out_valid_q;
    out_d       = out_q;
    pend_d      = pend_q;
    pend_res_d  = pend_res_q;
    if (load_ok) begin
      if (pend_q) begin
        out_valid_d = 1'b1;
        out_d       = pend_res_q;
        pend_d      = 1'b0;
      end else if (pop_o && emits) begin
        out_valid_d = 1'b1;
        out_d       = close_old ? old_res : new_res;
        pend_d      = close_old && close_new;
        pend_res_d  = new_res;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_color_q <= '0;
      run_count_q <= '0;
      column_q    <= '0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      run_color_q <= run_color_d;
      run_count_q <= run_count_d;
      column_q    <= column_d;
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    pend_res_q <= pend_res_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.run_len      = out_q.run_len;
  assign res_o.colour_idx   = out_q.colour_idx;
  assign res_o.end_of_line  = out_q.end_of_line;
  assign res_o.last_of_item = out_q.last_of_item;

  a_pend_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_valid_q)
    else $error("second run pending without a run on the output");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_count_q < RunW'(MaxRun)) && (column_q < ColW'(LineWidth)))
    else $error("open run or column out of range");

endmodule

`default_nettype wire

[hdl/palette_quantize_rle_encoder_top.sv]
// top level: nearest palette colour search followed by per-line run-length coding
// depends on pqrle_pkg, pqrle_if, pqrle_classify, pqrle_fifo, pqrle_rle
// a run closed by a pixel passes dist_q, grp_q, best_q, the queue and out_q in that order
// throughput: one pixel per cycle while the queue has room; a two-run pixel holds the encoder
// the colour search is a three-stage registered compare tree over the sixteen entries
// reset: palette entries, run colour, run count and column clear to zero, queue empties
`timescale 1ns / 1ps
`default_nettype none

module palette_quantize_rle_encoder_top import pqrle_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  pqrle_pix_if.sink    pix_i,
  pqrle_cfg_if.sink    cfg_i,
  pqrle_res_if.source  res_o
);

  qpush_t q_push;
  qhead_t q_head;
  logic   q_full;
  logic   q_pop;

  pqrle_classify u_classify (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pix_i    (pix_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .push_o   (q_push)
  );

  pqrle_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .pop_i  (q_pop),
    .full_o (q_full),
    .head_o (q_head)
  );

  pqrle_rle u_rle (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (q_head),
    .pop_o  (q_pop),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire
